### design/seval_pkg.sv
// ----------------------------------------------------------------------------
// seval_pkg
// Shared types, sizes and codes of the stack expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package seval_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int OUT_W       = 32;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W  = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [COUNT_W-1:0]     count_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_BUSY,
    S_EMIT
  } state_e;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_e;

  typedef struct packed {
    logic   start;
    md_op_e op;
  } md_req_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    value_t wdata;
    logic   re;
    addr_t  raddr;
  } ram_req_t;

endpackage

`default_nettype wire

### design/stack_expression_evaluator.sv
// ----------------------------------------------------------------------------
// stack_expression_evaluator
// Postfix / prefix evaluator over a RAM-backed stack with a cached top entry.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o  | symbol_i, end_of_expression_i
//   out     | output    | out_valid_o/out_ready_i| value_o, status_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_operand_order_i
//
// Digits, ignored characters and operators short of two entries are handled in
// S_IDLE; + and - and a / by zero also pass S_READ (one RAM read for the second
// entry), other * and / go on through S_BUSY in the bit-serial unit.
// An end-marked word then passes S_EMIT to load the output register, and waits
// there while a previous result is not taken.
// Reset clears the count, status and handshakes; no RAM clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_expression_evaluator import seval_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        symbol_i,
  input  logic              end_of_expression_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [OUT_W-1:0] value_o,
  output logic [2:0]        status_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_operand_order_i
);

  state_e  state_q, state_d;
  count_t  count_q, count_d;
  status_e err_q, err_d;
  logic    order_q;
  value_t  tos_q, tos_d;
  op_e     op_q, op_d;
  logic    eoe_q, eoe_d;

  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  value_q, value_d;
  status_e           status_q, status_d;

  ram_req_t ram_req;
  value_t   ram_rdata;
  md_req_t  md_req;
  logic     md_done;
  value_t   md_result;

  logic   accept;
  logic   is_digit;
  logic   is_op;
  op_e    op_dec;
  value_t lhs;
  value_t rhs;
  state_e after_op;

  seval_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  seval_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .lhs_i    (lhs),
    .rhs_i    (rhs),
    .done_o   (md_done),
    .result_o (md_result)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    is_digit = (symbol_i >= CH_ZERO) && (symbol_i <= CH_NINE);
    is_op    = 1'b1;
    case (symbol_i)
      CH_PLUS:  op_dec = OP_ADD;
      CH_MINUS: op_dec = OP_SUB;
      CH_STAR:  op_dec = OP_MUL;
      CH_SLASH: op_dec = OP_DIV;
      default: begin
        op_dec = OP_ADD;
        is_op  = 1'b0;
      end
    endcase
  end

  // Writes only happen on digit words in S_IDLE and reads are issued on
  // operator words, so the RAM never sees both on one entry in one cycle.
  always_comb begin
    lhs      = order_q ? tos_q : ram_rdata;
    rhs      = order_q ? ram_rdata : tos_q;
    after_op = eoe_q ? S_EMIT : S_IDLE;

    state_d     = state_q;
    count_d     = count_q;
    err_d       = err_q;
    tos_d       = tos_q;
    op_d        = op_q;
    eoe_d       = eoe_q;
    out_valid_d = out_valid_q && !out_ready_i;
    value_d     = value_q;
    status_d    = status_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = ADDR_W'(count_q - COUNT_W'(1));
    ram_req.wdata = tos_q;
    ram_req.re    = 1'b0;
    ram_req.raddr = ADDR_W'(count_q - COUNT_W'(2));

    md_req.start = 1'b0;
    md_req.op    = (op_q == OP_DIV) ? MD_DIV : MD_MUL;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          eoe_d   = end_of_expression_i;
          op_d    = op_dec;
          state_d = end_of_expression_i ? S_EMIT : S_IDLE;
          if (is_digit) begin
            if (count_q == COUNT_W'(STACK_DEPTH)) begin
              if (err_q == ST_OK) err_d = ST_OVER;
            end else begin
              // spill the old top, cache the digit
              ram_req.we = (count_q != '0);
              tos_d      = value_t'(symbol_i[3:0]);
              count_d    = count_q + COUNT_W'(1);
            end
          end else if (is_op) begin
            if (count_q < COUNT_W'(2)) begin
              if (err_q == ST_OK) err_d = ST_UNDER;
            end else begin
              ram_req.re = 1'b1;
              state_d    = S_READ;
            end
          end
        end
      end
      S_READ: begin
        case (op_q)
          OP_ADD: begin
            tos_d   = lhs + rhs;
            count_d = count_q - COUNT_W'(1);
            state_d = after_op;
          end
          OP_SUB: begin
            tos_d   = lhs - rhs;
            count_d = count_q - COUNT_W'(1);
            state_d = after_op;
          end
          OP_MUL: begin
            md_req.start = 1'b1;
            state_d      = S_BUSY;
          end
          default: begin
            if (rhs == '0) begin
              if (err_q == ST_OK) err_d = ST_DIVZ;
              tos_d   = '0;
              count_d = count_q - COUNT_W'(1);
              state_d = after_op;
            end else begin
              md_req.start = 1'b1;
              state_d      = S_BUSY;
            end
          end
        endcase
      end
      S_BUSY: begin
        if (md_done) begin
          tos_d   = md_result;
          count_d = count_q - COUNT_W'(1);
          state_d = after_op;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (count_q != '0) begin
            value_d  = OUT_W'($signed(tos_q));
            status_d = err_q;
          end else begin
            value_d  = '0;
            status_d = (err_q == ST_OK) ? ST_EMPTY : err_q;
          end
          count_d = '0;
          err_d   = ST_OK;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      order_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_operand_order_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q    <= tos_d;
    op_q     <= op_d;
    eoe_q    <= eoe_d;
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(value_q);
  assign status_o    = status_q;

endmodule

`default_nettype wire

### design/seval_ram.sv
// ----------------------------------------------------------------------------
// seval_ram
// Stack store below the top entry: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module seval_ram import seval_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output value_t   rdata_o
);

  value_t mem [STACK_DEPTH];
  value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/seval_muldiv.sv
// ----------------------------------------------------------------------------
// seval_muldiv
// Iterative unit: shift-add multiply (low half) and restoring signed divide,
// one bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module seval_muldiv import seval_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  input  value_t  lhs_i,
  input  value_t  rhs_i,
  output logic    done_o,
  output value_t  result_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [STEP_W-1:0]    step_q, step_d;
  md_op_e               op_q, op_d;
  logic                 neg_q, neg_d;
  value_t               x_q, x_d;
  value_t               y_q, y_d;
  logic [VALUE_WIDTH:0] acc_q, acc_d;
  value_t               res_q, res_d;

  logic [VALUE_WIDTH:0] rsh;
  logic [VALUE_WIDTH:0] diff;
  logic [VALUE_WIDTH:0] acc_n;
  value_t               y_n;
  value_t               lhs_mag;
  value_t               rhs_mag;

  always_comb begin
    lhs_mag = lhs_i[VALUE_WIDTH-1] ? (~lhs_i + value_t'(1)) : lhs_i;
    rhs_mag = rhs_i[VALUE_WIDTH-1] ? (~rhs_i + value_t'(1)) : rhs_i;

    rsh  = {acc_q[VALUE_WIDTH-1:0], y_q[VALUE_WIDTH-1]};
    diff = rsh - {1'b0, x_q};

    if (op_q == MD_MUL) begin
      acc_n = {1'b0, acc_q[VALUE_WIDTH-1:0] + (y_q[0] ? x_q : '0)};
      y_n   = y_q >> 1;
    end else if (!diff[VALUE_WIDTH]) begin
      acc_n = diff;
      y_n   = {y_q[VALUE_WIDTH-2:0], 1'b1};
    end else begin
      acc_n = rsh;
      y_n   = {y_q[VALUE_WIDTH-2:0], 1'b0};
    end

    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    op_d   = op_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    res_d  = res_q;

    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      op_d   = req_i.op;
      acc_d  = '0;
      neg_d  = lhs_i[VALUE_WIDTH-1] ^ rhs_i[VALUE_WIDTH-1];
      if (req_i.op == MD_MUL) begin
        x_d = lhs_i;
        y_d = rhs_i;
      end else begin
        x_d = rhs_mag;
        y_d = lhs_mag;
      end
    end else if (busy_q) begin
      acc_d  = acc_n;
      y_d    = y_n;
      step_d = step_q + STEP_W'(1);
      if (op_q == MD_MUL) begin
        x_d = x_q << 1;
      end
      if (step_q == STEP_W'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == MD_MUL) begin
          res_d = acc_n[VALUE_WIDTH-1:0];
        end else begin
          res_d = neg_q ? (~y_n + value_t'(1)) : y_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack expression evaluator. A driver feeds
// character words from a queue and a shadow evaluator predicts each result.
// A monitor compares every emitted result in order, under random gaps on both
// channels, in postfix and prefix operand order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench import seval_pkg::*; ();

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CHOKE_CYCLES   = 300;
  localparam int PHASE_ITEMS    = 450;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } char_word_t;

  typedef struct {
    logic [OUT_W-1:0] value;
    status_e          status;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] symbol_i = '0;
  logic end_of_expression_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] value_o;
  logic [2:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_operand_order_i = 1'b0;

  char_word_t pending_chars[$];
  outcome_t   expected_outcomes[$];
  int         queued_total = 0;
  int         failures = 0;
  int         results_checked = 0;
  int         idle_cycles = 0;
  int         send_gap = 0;
  int         rx_hold = 0;
  logic       choked = 1'b0;
  logic       steady = 1'b0;

  // shadow copy of the evaluator state
  value_t  shadow_stack [STACK_DEPTH];
  int      shadow_depth = 0;
  status_e shadow_status = ST_OK;
  logic    prefix_order = 1'b0;

  stack_expression_evaluator uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .symbol_i            (symbol_i),
    .end_of_expression_i (end_of_expression_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .value_o             (value_o),
    .status_o            (status_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_operand_order_i (cfg_operand_order_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic void note_error(status_e code);
    if (shadow_status == ST_OK) shadow_status = code;
  endfunction

  function automatic value_t signed_quotient(value_t lhs, value_t rhs);
    if (rhs == '0) begin
      note_error(ST_DIVZ);
      return '0;
    end
    // negate by hand so the most negative value wraps instead of trapping
    if (rhs == '1) return -lhs;
    return $signed(lhs) / $signed(rhs);
  endfunction

  function automatic void evaluate_symbol(logic [7:0] sym, logic last);
    value_t   top1, top2, lhs, rhs, res;
    outcome_t outcome;
    if (sym >= CH_ZERO && sym <= CH_NINE) begin
      if (shadow_depth >= STACK_DEPTH) begin
        note_error(ST_OVER);
      end else begin
        shadow_stack[shadow_depth] = value_t'(sym - CH_ZERO);
        shadow_depth++;
      end
    end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH) begin
      if (shadow_depth < 2) begin
        note_error(ST_UNDER);
      end else begin
        top1 = shadow_stack[shadow_depth-1];
        top2 = shadow_stack[shadow_depth-2];
        shadow_depth -= 2;
        lhs = prefix_order ? top1 : top2;
        rhs = prefix_order ? top2 : top1;
        case (sym)
          CH_PLUS:  res = lhs + rhs;
          CH_MINUS: res = lhs - rhs;
          CH_STAR:  res = lhs * rhs;
          default:  res = signed_quotient(lhs, rhs);
        endcase
        shadow_stack[shadow_depth] = res;
        shadow_depth++;
      end
    end
    if (last) begin
      outcome.value  = '0;
      outcome.status = shadow_status;
      if (shadow_depth > 0) outcome.value = OUT_W'($signed(shadow_stack[shadow_depth-1]));
      else if (shadow_status == ST_OK) outcome.status = ST_EMPTY;
      expected_outcomes.push_back(outcome);
      shadow_depth  = 0;
      shadow_status = ST_OK;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic push_char(input logic [7:0] sym, input logic last);
    char_word_t w;
    w.sym  = sym;
    w.last = last;
    pending_chars.push_back(w);
    queued_total++;
  endtask

  task automatic mark_last();
    pending_chars[pending_chars.size()-1].last = 1'b1;
  endtask

  task automatic push_expr(input string text);
    for (int i = 0; i < text.len(); i++) push_char(text[i], i == text.len() - 1);
  endtask

  // operand and operator sequence that never underflows and ends with one entry
  task automatic queue_wellformed();
    int pushes, pushed, depth;
    pushes = $urandom_range(1, 14);
    pushed = 0;
    depth  = 0;
    while (pushed < pushes || depth > 1) begin
      if ($urandom_range(0, 99) < 12)
        push_char($urandom_range(0, 1) ? CH_SPACE : 8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      if (pushed < pushes && (depth < 2 || $urandom_range(0, 1) == 0)) begin
        push_char(random_digit(), 1'b0);
        pushed++;
        depth++;
      end else begin
        push_char(random_operator(), 1'b0);
        depth--;
      end
    end
    if ($urandom_range(0, 9) == 0) push_char(CH_SPACE, 1'b0);
    mark_last();
  endtask

  task automatic queue_noise();
    logic [7:0] s;
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 2))
        0:       s = 8'($urandom_range(0, 255));
        1:       s = random_digit();
        default: s = random_operator();
      endcase
      push_char(s, $urandom_range(0, 9) == 0);
    end
    mark_last();
  endtask

  task automatic queue_overflow_run();
    repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4)) push_char(random_digit(), 1'b0);
    if ($urandom_range(0, 1)) push_char(random_operator(), 1'b0);
    mark_last();
  endtask

  task automatic queue_random(input int count);
    int start, r;
    start = queued_total;
    while (queued_total - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) queue_wellformed();
      else if (r < 92) queue_noise();
      else queue_overflow_run();
    end
  endtask

  task automatic queue_directed();
    push_expr("9");
    push_expr("0");
    push_expr("34+");
    push_expr("27-");
    push_expr("99*");
    push_expr("07-2/");
    push_expr("50/");
    push_expr("+");
    push_expr(" ");
    push_char(8'h00, 1'b0);
    push_char(8'hff, 1'b0);
    push_expr("5");
    push_expr("12");
    push_expr("+50/");
    push_expr("11111111111111111");
    // 2^31 built from digits, then divided by minus one
    push_expr("88888888882**********01-/");
  endtask

  // hold until the block has drained, then let a slow operation finish
  task automatic settle();
    while (pending_chars.size() != 0 || in_valid_i || expected_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_operand_order(input logic order);
    @(posedge clk_i);
    cfg_operand_order_i <= order;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    prefix_order = order;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    char_word_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      symbol_i <= '0;
      end_of_expression_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) evaluate_symbol(symbol_i, end_of_expression_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          w = pending_chars.pop_front();
          symbol_i <= w.sym;
          end_of_expression_i <= w.last;
          in_valid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int g;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no expectation: value %0d status %0d", value_o, status_o);
          failures++;
        end else begin
          want = expected_outcomes.pop_front();
          if (value_o !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d", $signed(want.value), value_o);
            failures++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status_o);
            failures++;
          end
          results_checked++;
        end
      end
      // stall output long enough for the input side to back up
      if (!choked && results_checked >= 40) begin
        choked <= 1'b1;
        rx_hold <= CHOKE_CYCLES;
        out_ready_i <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ready_i <= 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          rx_hold <= g - 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_operand_order(1'b0);
    queue_directed();
    settle();
    for (int phase = 0; phase < 4; phase++) begin
      set_operand_order(phase % 2 == 0);
      steady = (phase == 2);
      queue_random(PHASE_ITEMS);
      settle();
    end
    if (failures == 0 && expected_outcomes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
